@@ rtl/core/tccw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text console cell writer package
// Command codes, microcode word layout, the control program and small tables.
// ----------------------------------------------------------------------------
package tccw_pkg;

    // Default screen geometry.
    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;

    localparam logic [7:0] TEXT_COLOR_RESET = 8'd79;
    localparam logic [7:0] CHAR_ZERO        = 8'h30;
    localparam logic [7:0] CHAR_UPPER_A     = 8'h41;

    // Field widths.
    localparam int OPCODE_W  = 3;
    localparam int IN_DATA_W = 64;
    localparam int OUT_DATA_W = 32;
    localparam int ADDR_W    = 12;
    localparam int WORD_W    = 16;

    // Command codes.
    localparam logic [2:0] OPC_WRITE_CHAR = 3'd0;
    localparam logic [2:0] OPC_NEW_LINE   = 3'd1;
    localparam logic [2:0] OPC_SET_CURSOR = 3'd2;
    localparam logic [2:0] OPC_DECIMAL    = 3'd3;
    localparam logic [2:0] OPC_HEX        = 3'd4;
    localparam logic [2:0] OPC_PUT_AT     = 3'd5;

    // Datapath operations.
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_LOAD_COLD = 4'd1;  // dividend = column + 1
    localparam logic [3:0] OP_DIV_COL   = 4'd2;  // quotient of the dividend by COLUMNS
    localparam logic [3:0] OP_LOAD_ROWD = 4'd3;  // column = remainder, dividend = row + quotient
    localparam logic [3:0] OP_FAST_ADV  = 4'd4;  // column = column + 1
    localparam logic [3:0] OP_LOAD_NL   = 4'd5;  // column = 0, dividend = row + 1
    localparam logic [3:0] OP_DIV_ROW   = 4'd6;  // quotient of the dividend by ROWS
    localparam logic [3:0] OP_SET_ROW   = 4'd7;  // row = remainder
    localparam logic [3:0] OP_SET_CUR   = 4'd8;
    localparam logic [3:0] OP_LOAD_DEC  = 4'd9;
    localparam logic [3:0] OP_DABBLE    = 4'd10;
    localparam logic [3:0] OP_LOAD_HEX  = 4'd11;
    localparam logic [3:0] OP_SKIP      = 4'd12;
    localparam logic [3:0] OP_DIGIT     = 4'd13;

    // Cell write sources.
    localparam logic [2:0] EM_NONE  = 3'd0;
    localparam logic [2:0] EM_CHAR  = 3'd1;
    localparam logic [2:0] EM_ZERO  = 3'd2;
    localparam logic [2:0] EM_DIGIT = 3'd3;
    localparam logic [2:0] EM_PUT   = 3'd4;

    // Sequencer branch conditions.
    localparam logic [2:0] C_NEXT     = 3'd0;
    localparam logic [2:0] C_ALWAYS   = 3'd1;
    localparam logic [2:0] C_DISPATCH = 3'd2;
    localparam logic [2:0] C_FAST     = 3'd3;
    localparam logic [2:0] C_CNT_NZ   = 3'd4;
    localparam logic [2:0] C_ZERO     = 3'd5;
    localparam logic [2:0] C_TOP_NZ   = 3'd6;
    localparam logic [2:0] C_DIG_NZ   = 3'd7;

    // Program addresses.
    localparam int UPC_W = 5;
    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_WCHAR     = 5'd1;
    localparam logic [4:0] S_WC_DIV    = 5'd2;
    localparam logic [4:0] S_WC_ROW    = 5'd3;
    localparam logic [4:0] S_WC_FAST   = 5'd4;
    localparam logic [4:0] S_NL        = 5'd5;
    localparam logic [4:0] S_ROW_DIV   = 5'd6;
    localparam logic [4:0] S_ROW_SET   = 5'd7;
    localparam logic [4:0] S_SETCUR    = 5'd8;
    localparam logic [4:0] S_HEX       = 5'd9;
    localparam logic [4:0] S_SKIP      = 5'd10;
    localparam logic [4:0] S_DIGIT     = 5'd11;
    localparam logic [4:0] S_DEC       = 5'd12;
    localparam logic [4:0] S_DABBLE    = 5'd13;
    localparam logic [4:0] S_DEC_DONE  = 5'd14;
    localparam logic [4:0] S_ZERO      = 5'd15;
    localparam logic [4:0] S_PUT       = 5'd16;

    typedef struct packed {
        logic [3:0]       op;
        logic [2:0]       emit;
        logic [2:0]       cond;
        logic [UPC_W-1:0] target;
    } ucode_t;

    // The control program.
    function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] upc);
        ucode_t w;
        begin
            w = '{op: OP_NONE, emit: EM_NONE, cond: C_ALWAYS, target: S_IDLE};
            case (upc)
                S_IDLE:     w = '{OP_NONE,      EM_NONE,  C_DISPATCH, S_IDLE};
                S_WCHAR:    w = '{OP_LOAD_COLD, EM_CHAR,  C_FAST,     S_WC_FAST};
                S_WC_DIV:   w = '{OP_DIV_COL,   EM_NONE,  C_ALWAYS,   S_WC_ROW};
                S_WC_ROW:   w = '{OP_LOAD_ROWD, EM_NONE,  C_ALWAYS,   S_ROW_DIV};
                S_WC_FAST:  w = '{OP_FAST_ADV,  EM_NONE,  C_ALWAYS,   S_IDLE};
                S_NL:       w = '{OP_LOAD_NL,   EM_NONE,  C_ALWAYS,   S_ROW_DIV};
                S_ROW_DIV:  w = '{OP_DIV_ROW,   EM_NONE,  C_ALWAYS,   S_ROW_SET};
                S_ROW_SET:  w = '{OP_SET_ROW,   EM_NONE,  C_ALWAYS,   S_IDLE};
                S_SETCUR:   w = '{OP_SET_CUR,   EM_NONE,  C_ALWAYS,   S_IDLE};
                S_HEX:      w = '{OP_LOAD_HEX,  EM_NONE,  C_ZERO,     S_ZERO};
                S_SKIP:     w = '{OP_SKIP,      EM_NONE,  C_TOP_NZ,   S_DIGIT};
                S_DIGIT:    w = '{OP_DIGIT,     EM_DIGIT, C_DIG_NZ,   S_DIGIT};
                S_DEC:      w = '{OP_LOAD_DEC,  EM_NONE,  C_ZERO,     S_ZERO};
                S_DABBLE:   w = '{OP_DABBLE,    EM_NONE,  C_CNT_NZ,   S_DABBLE};
                S_DEC_DONE: w = '{OP_NONE,      EM_NONE,  C_ALWAYS,   S_SKIP};
                S_ZERO:     w = '{OP_NONE,      EM_ZERO,  C_ALWAYS,   S_IDLE};
                S_PUT:      w = '{OP_NONE,      EM_PUT,   C_ALWAYS,   S_IDLE};
                default:    w = '{OP_NONE,      EM_NONE,  C_ALWAYS,   S_IDLE};
            endcase
            return w;
        end
    endfunction

    // Entry point of each command's routine.
    function automatic logic [UPC_W-1:0] dispatch(input logic [OPCODE_W-1:0] opc);
        logic [UPC_W-1:0] a;
        begin
            case (opc)
                OPC_WRITE_CHAR: a = S_WCHAR;
                OPC_NEW_LINE:   a = S_NL;
                OPC_SET_CURSOR: a = S_SETCUR;
                OPC_DECIMAL:    a = S_DEC;
                OPC_HEX:        a = S_HEX;
                OPC_PUT_AT:     a = S_PUT;
                default:        a = S_IDLE;
            endcase
            return a;
        end
    endfunction

    // Character for one digit value.
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        begin
            if (d < 4'd10)
                c = CHAR_ZERO + {4'd0, d};
            else
                c = CHAR_UPPER_A + {4'd0, d} - 8'd10;
            return c;
        end
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/text_console_cell_writer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text console cell writer
// Turns console commands into attribute/character cell writes for a text
// screen, run by a small microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the s_axis channel, the command code in tuser and its
// operands in tdata. Each command yields zero to ten cell writes on the
// m_axis channel; tlast marks the final cell write of a command. The user
// must write the text attribute on the cfg channel only while the block is
// idle; the block itself does not enforce this. One command is handled at a
// time. The sequencer takes a new command only in its idle step; a finished
// cell sitting in the output register does not block that. Write char
// advances the column directly when the cursor stays on its row, and on a
// wrap runs two reciprocal divisions, each followed by a remainder step; new
// line runs the row division and its remainder step; hex skips leading zero
// digits, then writes the rest; decimal runs a double-dabble conversion, then
// the same digit loop. A zero value prints a single zero cell instead. The
// first cell appears in the cycle after its step runs.
// If the receiver stalls, the step that writes a cell waits until the
// output register is free, so nothing is lost or repeated.
// Reset clears the cursor to the top left, the attribute to 79 and empties
// the output register.
// ----------------------------------------------------------------------------
module text_console_cell_writer #(
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tccw_pkg::ROWS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration: text attribute byte.
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [7:0]  cfg_data,
    // Commands.
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    // tdata fields from bit 0: char_code[7:0], number_value[39:8],
    // target_row[44:40], target_column[51:45], fore_color[55:52],
    // back_color[59:56], zero padding[63:60].
    input  wire logic [tccw_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // tuser fields: opcode[2:0].
    input  wire logic [tccw_pkg::OPCODE_W-1:0]  s_axis_tuser,
    // Cell writes.
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata fields from bit 0: cell_address[11:0], cell_word[27:12],
    // zero padding[31:28].
    output      logic [tccw_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // tlast carries last_write.
    output      logic        m_axis_tlast
);
    import tccw_pkg::*;

    localparam logic [7:0] COL_D = 8'(COLUMNS);
    localparam logic [7:0] ROW_D = 8'(ROWS);

    // Reciprocals for the quotient by multiplication; exact for every
    // nine-bit dividend and divisors up to 255.
    localparam int          RECIP_SHIFT = 18;
    localparam logic [18:0] COL_RECIP   = 19'(((1 << RECIP_SHIFT) + COLUMNS - 1) / COLUMNS);
    localparam logic [18:0] ROW_RECIP   = 19'(((1 << RECIP_SHIFT) + ROWS - 1) / ROWS);

    // Sequencer.
    logic [UPC_W-1:0] upc_reg, upc_next;
    ucode_t           uw;
    logic             step_go;
    logic             emit_go;

    // Architectural state.
    logic [7:0] text_color_reg;
    logic [4:0] row_reg, row_next;
    logic [7:0] col_reg, col_next;

    // Captured command operands.
    logic [7:0]  char_reg;
    logic [31:0] num_reg;
    logic [4:0]  trow_reg;
    logic [6:0]  tcol_reg;
    logic [3:0]  fg_reg;
    logic [3:0]  bg_reg;

    // Datapath working registers.
    logic [8:0]  dvd_reg, dvd_next;   // dividend
    logic [8:0]  quo_reg, quo_next;
    logic [5:0]  cnt_reg, cnt_next;   // loop counter for the dabble
    logic [31:0] bin_reg, bin_next;
    logic [39:0] work_reg, work_next; // ten digit nibbles, most significant on top
    logic [3:0]  dig_reg, dig_next;   // digits left in work_reg

    // Output register.
    logic        out_valid_reg;
    logic [11:0] out_addr_reg;
    logic [15:0] out_word_reg;
    logic        out_last_reg;

    // Helpers.
    logic [7:0]  divisor;
    logic [18:0] recip;
    logic [27:0] quo_prod;
    logic [16:0] quo_times;
    logic [8:0]  div_rem;
    logic        fast_adv;
    logic [3:0]  top_digit;
    logic [39:0] dabble_adj;
    logic [3:0]  nib;
    logic [13:0] cur_addr;
    logic [13:0] put_addr;
    logic [11:0] cell_addr;
    logic [7:0]  cell_attr;
    logic [7:0]  cell_char;
    logic        cell_last;

    assign uw        = ucode_rom(upc_reg);
    assign cfg_ready = 1'b1;
    assign s_axis_tready = (upc_reg == S_IDLE);

    assign emit_go = (uw.emit != EM_NONE) && (!out_valid_reg || m_axis_tready);
    assign step_go = (uw.emit == EM_NONE) || emit_go;

    assign fast_adv  = ({1'b0, col_reg} + 9'd1 < {1'b0, COL_D}) && ({3'b0, row_reg} < ROW_D);
    assign top_digit = work_reg[39:36];

    // Quotient step multiplies by the reciprocal; the following step takes
    // the remainder as dividend minus quotient times divisor.
    assign divisor   = ((uw.op == OP_DIV_ROW) || (uw.op == OP_SET_ROW)) ? ROW_D : COL_D;
    assign recip     = (uw.op == OP_DIV_ROW) ? ROW_RECIP : COL_RECIP;
    assign quo_prod  = 28'(dvd_reg) * 28'(recip);
    assign quo_times = 17'(quo_reg) * 17'(divisor);
    assign div_rem   = dvd_reg - quo_times[8:0];

    // Cell address and contents of the write in this step.
    assign cur_addr = 14'(row_reg) * 14'(COL_D) + 14'(col_reg);
    assign put_addr = 14'(trow_reg) * 14'(COL_D) + 14'(tcol_reg);

    always_comb
    begin
        cell_addr = cur_addr[11:0];
        cell_attr = text_color_reg;
        cell_char = char_reg;
        cell_last = 1'b1;
        case (uw.emit)
            EM_CHAR:
            begin
                cell_char = char_reg;
            end
            EM_ZERO:
            begin
                cell_char = CHAR_ZERO;
            end
            EM_DIGIT:
            begin
                cell_char = digit_char(top_digit);
                cell_last = (dig_reg == 4'd1);
            end
            EM_PUT:
            begin
                cell_addr = put_addr[11:0];
                cell_attr = {bg_reg, fg_reg};
            end
            default:
            begin
                cell_char = char_reg;
            end
        endcase
    end

    // Add-3 correction of every BCD nibble before the next shift.
    always_comb
    begin
        dabble_adj = work_reg;
        for (int i = 0; i < 10; i++)
        begin
            nib = work_reg[i*4 +: 4];
            dabble_adj[i*4 +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
        end
    end

    // Datapath driven by the control word.
    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        work_next = work_reg;
        dig_next  = dig_reg;
        case (uw.op)
            OP_LOAD_COLD:
            begin
                dvd_next = {1'b0, col_reg} + 9'd1;
            end
            OP_DIV_COL, OP_DIV_ROW:
            begin
                quo_next = quo_prod[RECIP_SHIFT +: 9];
            end
            OP_LOAD_ROWD:
            begin
                col_next = div_rem[7:0];
                dvd_next = {4'd0, row_reg} + quo_reg;
            end
            OP_FAST_ADV:
            begin
                col_next = col_reg + 8'd1;
            end
            OP_LOAD_NL:
            begin
                col_next = 8'd0;
                dvd_next = {4'd0, row_reg} + 9'd1;
            end
            OP_SET_ROW:
            begin
                row_next = div_rem[4:0];
            end
            OP_SET_CUR:
            begin
                row_next = trow_reg;
                col_next = {1'b0, tcol_reg};
            end
            OP_LOAD_DEC:
            begin
                bin_next  = num_reg;
                work_next = 40'd0;
                cnt_next  = 6'd32;
                dig_next  = 4'd10;
            end
            OP_DABBLE:
            begin
                work_next = {dabble_adj[38:0], bin_reg[31]};
                bin_next  = {bin_reg[30:0], 1'b0};
                cnt_next  = cnt_reg - 6'd1;
            end
            OP_LOAD_HEX:
            begin
                work_next = {8'd0, num_reg};
                dig_next  = 4'd10;
            end
            OP_SKIP:
            begin
                if (top_digit == 4'd0)
                begin
                    work_next = {work_reg[35:0], 4'd0};
                    dig_next  = dig_reg - 4'd1;
                end
            end
            OP_DIGIT:
            begin
                work_next = {work_reg[35:0], 4'd0};
                dig_next  = dig_reg - 4'd1;
                col_next  = (col_reg == 8'd255) ? col_reg : col_reg + 8'd1;
            end
            default:
            begin
                work_next = work_reg;
            end
        endcase
    end

    // Step counter and branches.
    always_comb
    begin
        upc_next = upc_reg;
        if (step_go)
        begin
            case (uw.cond)
                C_NEXT:     upc_next = upc_reg + 5'd1;
                C_ALWAYS:   upc_next = uw.target;
                C_DISPATCH: upc_next = s_axis_tvalid ? dispatch(s_axis_tuser) : S_IDLE;
                C_FAST:     upc_next = fast_adv ? uw.target : upc_reg + 5'd1;
                C_CNT_NZ:   upc_next = (cnt_reg != 6'd1) ? uw.target : upc_reg + 5'd1;
                C_ZERO:     upc_next = (num_reg == 32'd0) ? uw.target : upc_reg + 5'd1;
                C_TOP_NZ:   upc_next = (top_digit != 4'd0) ? uw.target : upc_reg;
                C_DIG_NZ:   upc_next = (dig_reg != 4'd1) ? uw.target : S_IDLE;
                default:    upc_next = S_IDLE;
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg        <= S_IDLE;
            text_color_reg <= TEXT_COLOR_RESET;
            row_reg        <= 5'd0;
            col_reg        <= 8'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            upc_reg <= upc_next;
            if (cfg_valid && cfg_ready)
                text_color_reg <= cfg_data;
            if (step_go)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
            if (emit_go)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            char_reg <= s_axis_tdata[7:0];
            num_reg  <= s_axis_tdata[39:8];
            trow_reg <= s_axis_tdata[44:40];
            tcol_reg <= s_axis_tdata[51:45];
            fg_reg   <= s_axis_tdata[55:52];
            bg_reg   <= s_axis_tdata[59:56];
        end
        if (step_go)
        begin
            dvd_reg  <= dvd_next;
            quo_reg  <= quo_next;
            cnt_reg  <= cnt_next;
            bin_reg  <= bin_next;
            work_reg <= work_next;
            dig_reg  <= dig_next;
        end
        if (emit_go)
        begin
            out_addr_reg <= cell_addr;
            out_word_reg <= {cell_attr, cell_char};
            out_last_reg <= cell_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_word_reg, out_addr_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cell writer testbench
// Feeds console commands into the writer through its command stream and
// checks every cell write that comes back against a cycle-free model of the
// cursor, the text attribute and the number printing. A directed opening
// covers the field extremes and the corner cases. Three random phases follow:
// the receiver idles more, then the sender, then neither. Each phase runs
// under its own text attribute, and the last one includes a long receiver
// hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    import tccw_pkg::*;

    localparam int SCREEN_COLUMNS = COLUMNS_DEFAULT;
    localparam int SCREEN_ROWS    = ROWS_DEFAULT;

    // Command codes the block ignores.
    localparam logic [2:0] OPC_RESERVED_6 = 3'd6;
    localparam logic [2:0] OPC_RESERVED_7 = 3'd7;

    localparam int RESET_CYCLES   = 10;
    // Covers the longest command, a decimal print.
    localparam int SETTLE_CYCLES  = 60;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  char_code;
        logic [31:0] number_value;
        logic [4:0]  target_row;
        logic [6:0]  target_column;
        logic [3:0]  fore_color;
        logic [3:0]  back_color;
    } command_t;

    typedef struct packed {
        logic [11:0] cell_address;
        logic [15:0] cell_word;
        logic        last_write;
    } cell_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // Fields from bit 0: char_code, number_value, target_row, target_column,
    // fore_color, back_color, zero padding.
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    // Fields from bit 0: opcode.
    logic [OPCODE_W-1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // Fields from bit 0: cell_address, cell_word, zero padding.
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic        m_axis_tlast;

    text_console_cell_writer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Commands waiting to be sent and cell writes still owed by the block.
    command_t pending_commands[$];
    cell_t    expected_cells[$];

    // Model state: cursor and current text attribute.
    logic [4:0] cursor_row_q  = 5'd0;
    logic [7:0] cursor_col_q  = 8'd0;
    logic [7:0] text_attr     = TEXT_COLOR_RESET;

    int  sender_idle_pct   = 0;
    int  receiver_idle_pct = 0;
    bit  hold_request      = 1'b0;
    bit  hold_served       = 1'b0;
    int  hold_left         = 0;
    bit  sender_holding;
    int  commands_queued   = 0;
    int  cells_checked     = 0;
    int  attr_settings     = 1;
    int  error_count       = 0;
    int  quiet_cycles      = 0;
    int  opcode_count[8];
    cell_t want_cell;

    // Queue one cell write at row * columns + column, wrapped to 12 bits.
    task automatic push_cell(input logic [4:0] row, input logic [7:0] col,
                             input logic [7:0] attr, input logic [7:0] ch,
                             input logic last);
        cell_t c;
        int    a;
        a = (int'(row) * SCREEN_COLUMNS + int'(col)) % 4096;
        c.cell_address = a[11:0];
        c.cell_word    = {attr, ch};
        c.last_write   = last;
        expected_cells.push_back(c);
    endtask

    // Work out the cell writes of one accepted command and update the cursor.
    task automatic predict_cells(input command_t c);
        logic [3:0]  digits[10];
        logic [31:0] v;
        logic [31:0] base;
        logic [3:0]  d;
        logic [7:0]  ch;
        int          n;
        int          k;
        int          pos;
        case (c.opcode)
            OPC_WRITE_CHAR:
            begin
                push_cell(cursor_row_q, cursor_col_q, text_attr, c.char_code, 1'b1);
                // Advance in linear order, so the row end and the screen bottom
                // both wrap, and an off-screen cursor folds back in.
                pos = int'(cursor_row_q) * SCREEN_COLUMNS + int'(cursor_col_q) + 1;
                cursor_row_q = 5'((pos / SCREEN_COLUMNS) % SCREEN_ROWS);
                cursor_col_q = 8'(pos % SCREEN_COLUMNS);
            end
            OPC_NEW_LINE:
            begin
                cursor_col_q = 8'd0;
                cursor_row_q = 5'((int'(cursor_row_q) + 1) % SCREEN_ROWS);
            end
            OPC_SET_CURSOR:
            begin
                cursor_row_q = c.target_row;
                cursor_col_q = {1'b0, c.target_column};
            end
            OPC_DECIMAL, OPC_HEX:
            begin
                base = (c.opcode == OPC_DECIMAL) ? 32'd10 : 32'd16;
                v = c.number_value;
                if (v == 32'd0)
                begin
                    // A zero prints a single '0' and leaves the cursor alone.
                    push_cell(cursor_row_q, cursor_col_q, text_attr, CHAR_ZERO, 1'b1);
                end
                else
                begin
                    n = 0;
                    while (v != 32'd0)
                    begin
                        digits[n] = 4'(v % base);
                        v = v / base;
                        n++;
                    end
                    // Most significant digit first; the column never wraps here
                    // and sticks at 255.
                    for (k = n - 1; k >= 0; k--)
                    begin
                        d = digits[k];
                        ch = (d < 4'd10) ? CHAR_ZERO + {4'd0, d}
                                         : CHAR_UPPER_A + {4'd0, d} - 8'd10;
                        push_cell(cursor_row_q, cursor_col_q, text_attr, ch, k == 0);
                        if (cursor_col_q < 8'd255)
                            cursor_col_q++;
                    end
                end
            end
            OPC_PUT_AT:
                push_cell(c.target_row, {1'b0, c.target_column},
                          {c.back_color, c.fore_color}, c.char_code, 1'b1);
            default:
                ;
        endcase
    endtask

    // Command driver: holds an offered command until it is taken, then picks
    // the next one from the queue or idles at the phase's rate.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_cells(pending_commands[0]);
                opcode_count[pending_commands[0].opcode]++;
                pending_commands.delete(0);
                sender_holding = 1'b0;
            end
            else
            begin
                sender_holding = s_axis_tvalid;
            end
            if (!sender_holding)
            begin
                if (pending_commands.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {4'd0, pending_commands[0].back_color,
                                      pending_commands[0].fore_color,
                                      pending_commands[0].target_column,
                                      pending_commands[0].target_row,
                                      pending_commands[0].number_value,
                                      pending_commands[0].char_code};
                    s_axis_tuser  <= pending_commands[0].opcode;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready: random back-pressure, plus one long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (hold_request && !hold_served)
            begin
                hold_left = HOLD_CYCLES;
                hold_served = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    // Cell write monitor: every transaction on the output must match the
    // oldest outstanding expectation, field by field.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_cells.size() == 0)
            begin
                $error("cell write with none expected: tdata %h, tlast %b",
                       m_axis_tdata, m_axis_tlast);
                error_count++;
            end
            else
            begin
                want_cell = expected_cells.pop_front();
                cells_checked++;
                if (m_axis_tdata[11:0] !== want_cell.cell_address)
                begin
                    $error("cell_address: expected %0d, actual %0d",
                           want_cell.cell_address, m_axis_tdata[11:0]);
                    error_count++;
                end
                if (m_axis_tdata[27:12] !== want_cell.cell_word)
                begin
                    $error("cell_word: expected %h, actual %h",
                           want_cell.cell_word, m_axis_tdata[27:12]);
                    error_count++;
                end
                if (m_axis_tdata[31:28] !== 4'd0)
                begin
                    $error("tdata padding: expected 0, actual %h", m_axis_tdata[31:28]);
                    error_count++;
                end
                if (m_axis_tlast !== want_cell.last_write)
                begin
                    $error("last_write: expected %b, actual %b",
                           want_cell.last_write, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: a long run of cycles without any transaction means a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $error("no transaction for %0d cycles, %0d cell writes still expected",
                       quiet_cycles, expected_cells.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic queue_command(input logic [2:0] opc, input logic [7:0] ch,
                                 input logic [31:0] num, input logic [4:0] row,
                                 input logic [6:0] col, input logic [3:0] fg,
                                 input logic [3:0] bg);
        command_t c;
        c = '{opc, ch, num, row, col, fg, bg};
        pending_commands.push_back(c);
        commands_queued++;
    endtask

    // Numbers of every length, with zero and the all-ones value well represented.
    function automatic logic [31:0] pick_number_value();
        logic [31:0] value;
        case ($urandom_range(7))
            0:       value = 32'd0;
            1:       value = $urandom_range(9, 1);
            2:       value = $urandom_range(9999, 10);
            3:       value = 32'hFFFF_FFFF;
            4, 5:    value = $urandom >> $urandom_range(31);
            default: value = $urandom;
        endcase
        return value;
    endfunction

    // One command with a weighted opcode; all fields, used or not, are random.
    task automatic queue_random_command();
        int          r;
        logic [2:0]  opc;
        r = $urandom_range(99);
        if (r < 30)
            opc = OPC_WRITE_CHAR;
        else if (r < 38)
            opc = OPC_NEW_LINE;
        else if (r < 48)
            opc = OPC_SET_CURSOR;
        else if (r < 63)
            opc = OPC_DECIMAL;
        else if (r < 78)
            opc = OPC_HEX;
        else if (r < 93)
            opc = OPC_PUT_AT;
        else if (r < 96)
            opc = OPC_RESERVED_6;
        else
            opc = OPC_RESERVED_7;
        queue_command(opc, 8'($urandom), pick_number_value(), 5'($urandom_range(31)),
                      7'($urandom_range(127)), 4'($urandom), 4'($urandom));
    endtask

    // Park the cursor far right and print long numbers until the column
    // sticks at 255, then let write char fold it back onto the screen.
    task automatic queue_saturation_run();
        int k;
        queue_command(OPC_SET_CURSOR, 8'($urandom), $urandom, 5'($urandom_range(31)),
                      7'($urandom_range(127, 110)), 4'($urandom), 4'($urandom));
        for (k = 0; k < 16; k++)
        begin
            if ($urandom_range(3) == 0)
                queue_command(OPC_HEX, 8'($urandom),
                              $urandom_range(32'hFFFF_FFFF, 32'h1000_0000),
                              5'($urandom), 7'($urandom), 4'($urandom), 4'($urandom));
            else
                queue_command(OPC_DECIMAL, 8'($urandom),
                              $urandom_range(32'hFFFF_FFFF, 32'd1_000_000_000),
                              5'($urandom), 7'($urandom), 4'($urandom), 4'($urandom));
        end
        queue_command(OPC_WRITE_CHAR, 8'($urandom), $urandom, 5'($urandom), 7'($urandom),
                      4'($urandom), 4'($urandom));
        queue_command(OPC_WRITE_CHAR, 8'($urandom), $urandom, 5'($urandom), 7'($urandom),
                      4'($urandom), 4'($urandom));
    endtask

    // Random traffic, mostly short console sequences that reach the wrap and
    // fold paths, mixed with single commands of any kind.
    task automatic queue_random_run(input int count);
        int start;
        int r;
        start = commands_queued;
        while (commands_queued - start < count)
        begin
            r = $urandom_range(99);
            if (r < 50)
            begin
                queue_random_command();
            end
            else if (r < 75)
            begin
                // Near the row end, often on the bottom row, then keep typing.
                queue_command(OPC_SET_CURSOR, 8'($urandom), $urandom,
                              $urandom_range(1) ? 5'd24 : 5'($urandom_range(24)),
                              7'($urandom_range(79, 76)), 4'($urandom), 4'($urandom));
                repeat ($urandom_range(6, 2))
                begin
                    if ($urandom_range(4) == 0)
                        queue_random_command();
                    else
                        queue_command(OPC_WRITE_CHAR, 8'($urandom), $urandom, 5'($urandom),
                                      7'($urandom), 4'($urandom), 4'($urandom));
                end
            end
            else if (r < 90)
            begin
                // Anywhere the fields reach, including off the screen.
                queue_command(OPC_SET_CURSOR, 8'($urandom), $urandom,
                              5'($urandom_range(31)), 7'($urandom_range(127)),
                              4'($urandom), 4'($urandom));
                repeat ($urandom_range(3, 1))
                    queue_random_command();
            end
            else
            begin
                repeat ($urandom_range(4, 1))
                    queue_command(OPC_NEW_LINE, 8'($urandom), $urandom, 5'($urandom),
                                  7'($urandom), 4'($urandom), 4'($urandom));
                queue_command(OPC_WRITE_CHAR, 8'($urandom), $urandom, 5'($urandom),
                              7'($urandom), 4'($urandom), 4'($urandom));
            end
        end
    endtask

    // Wait until every command has been taken and every cell write has come
    // back, then give a command with no output time to finish.
    task automatic wait_until_idle();
        do
            @(negedge clk);
        while (pending_commands.size() != 0 || s_axis_tvalid || expected_cells.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One transaction on the configuration channel; the model follows it.
    task automatic write_text_color(input logic [7:0] attr);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= attr;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        text_attr = attr;
        attr_settings++;
        @(negedge clk);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Phase 1: the sender idles often, the receiver most of the time.
        sender_idle_pct   = 37;
        receiver_idle_pct = 87;

        // Directed opening, still under the reset attribute.
        queue_command(OPC_WRITE_CHAR, 8'h00, 32'd0, 5'd0, 7'd0, 4'd0, 4'd0);
        queue_command(OPC_WRITE_CHAR, 8'hFF, 32'd0, 5'd0, 7'd0, 4'd0, 4'd0);
        queue_command(OPC_WRITE_CHAR, 8'h80, 32'd0, 5'd0, 7'd0, 4'd0, 4'd0);
        queue_command(OPC_NEW_LINE, 8'h00, 32'd0, 5'd0, 7'd0, 4'd0, 4'd0);
        // Wrap at the row end, then at the bottom right corner.
        queue_command(OPC_SET_CURSOR, 8'h00, 32'd0, 5'd0, 7'd79, 4'd0, 4'd0);
        queue_command(OPC_WRITE_CHAR, 8'h41, 32'd0, 5'd0, 7'd0, 4'd0, 4'd0);
        queue_command(OPC_SET_CURSOR, 8'h00, 32'd0, 5'd24, 7'd79, 4'd0, 4'd0);
        queue_command(OPC_WRITE_CHAR, 8'h7F, 32'd0, 5'd0, 7'd0, 4'd0, 4'd0);
        // Zero in both bases, the largest value, hex letters, a power of ten.
        queue_command(OPC_DECIMAL, 8'h00, 32'd0, 5'd0, 7'd0, 4'd0, 4'd0);
        queue_command(OPC_HEX, 8'h00, 32'd0, 5'd0, 7'd0, 4'd0, 4'd0);
        queue_command(OPC_DECIMAL, 8'h00, 32'hFFFF_FFFF, 5'd0, 7'd0, 4'd0, 4'd0);
        queue_command(OPC_HEX, 8'h00, 32'hFFFF_FFFF, 5'd0, 7'd0, 4'd0, 4'd0);
        queue_command(OPC_HEX, 8'h00, 32'h0000_000A, 5'd0, 7'd0, 4'd0, 4'd0);
        queue_command(OPC_HEX, 8'h00, 32'h89AB_CDEF, 5'd0, 7'd0, 4'd0, 4'd0);
        queue_command(OPC_DECIMAL, 8'h00, 32'd1_000_000_000, 5'd0, 7'd0, 4'd0, 4'd0);
        // Put at both corners of the field ranges, colors at their extremes.
        queue_command(OPC_PUT_AT, 8'h00, 32'd0, 5'd0, 7'd0, 4'd0, 4'd0);
        queue_command(OPC_PUT_AT, 8'hFF, 32'd0, 5'd31, 7'd127, 4'd15, 4'd15);
        // Cursor off the screen, then write char folds it back.
        queue_command(OPC_SET_CURSOR, 8'h00, 32'd0, 5'd31, 7'd127, 4'd0, 4'd0);
        queue_command(OPC_WRITE_CHAR, 8'h5A, 32'd0, 5'd0, 7'd0, 4'd0, 4'd0);
        // Unused command codes, with every field set, must do nothing.
        queue_command(OPC_RESERVED_6, 8'hFF, 32'hFFFF_FFFF, 5'd31, 7'd127, 4'd15, 4'd15);
        queue_command(OPC_RESERVED_7, 8'hFF, 32'hFFFF_FFFF, 5'd31, 7'd127, 4'd15, 4'd15);
        // New line on the bottom row returns to the top.
        queue_command(OPC_SET_CURSOR, 8'h00, 32'd0, 5'd24, 7'd5, 4'd0, 4'd0);
        queue_command(OPC_NEW_LINE, 8'h00, 32'd0, 5'd0, 7'd0, 4'd0, 4'd0);
        queue_command(OPC_SET_CURSOR, 8'h00, 32'd0, 5'd3, 7'd0, 4'd0, 4'd0);
        queue_command(OPC_DECIMAL, 8'h00, 32'd7, 5'd0, 7'd0, 4'd0, 4'd0);
        wait_until_idle();

        write_text_color(8'hFF);
        queue_saturation_run();
        queue_random_run(55);
        // The sender stops here until the block has caught up completely.
        wait_until_idle();
        queue_random_run(55);
        wait_until_idle();

        // Phase 2: roles swapped, the sender is the slow side.
        sender_idle_pct   = 87;
        receiver_idle_pct = 37;
        write_text_color(8'h00);
        queue_saturation_run();
        queue_random_run(110);
        wait_until_idle();

        // Phase 3: no idling at all, plus one long receiver hold-off while the
        // sender keeps offering, so the block backs up into its input.
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        write_text_color(8'($urandom_range(254, 1)));
        queue_saturation_run();
        queue_random_run(110);
        hold_request = 1'b1;
        wait_until_idle();

        $display("Run covered %0d commands: %0d write char, %0d new line, %0d set cursor,",
                 opcode_count.sum(), opcode_count[OPC_WRITE_CHAR], opcode_count[OPC_NEW_LINE],
                 opcode_count[OPC_SET_CURSOR]);
        $display("%0d decimal, %0d hex, %0d put at, %0d unused; %0d cell writes, %0d attributes.",
                 opcode_count[OPC_DECIMAL], opcode_count[OPC_HEX], opcode_count[OPC_PUT_AT],
                 opcode_count[OPC_RESERVED_6] + opcode_count[OPC_RESERVED_7], cells_checked,
                 attr_settings);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
